// ===== rtl/pip_pkg.sv =====
package pip_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t vx;
        coord_t vy;
        coord_t vz;
        coord_t qx;
        coord_t qy;
        coord_t qz;
        coord_t nx;
        coord_t ny;
        coord_t nz;
        logic   first;
        logic   last;
    } vert_t;

    // one edge test: crossing when in_range and lhs < rhs
    typedef struct packed {
        logic                     in_range;
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
    } edge_prod_t;

    typedef struct packed {
        edge_prod_t e_open;
        edge_prod_t e_close;
        logic       first;
        logic       last;
        axis_t      axis;
    } edge_pair_t;

endpackage

// ===== rtl/pip_vert_if.sv =====
interface pip_vert_if;
    logic                 valid;
    logic                 ready;
    pip_pkg::coord_t      vert_x;
    pip_pkg::coord_t      vert_y;
    pip_pkg::coord_t      vert_z;
    pip_pkg::coord_t      query_x;
    pip_pkg::coord_t      query_y;
    pip_pkg::coord_t      query_z;
    pip_pkg::coord_t      norm_x;
    pip_pkg::coord_t      norm_y;
    pip_pkg::coord_t      norm_z;
    logic                 first_vertex;
    logic                 last_vertex;

    modport source (
        output valid, vert_x, vert_y, vert_z, query_x, query_y, query_z,
               norm_x, norm_y, norm_z, first_vertex, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vert_x, vert_y, vert_z, query_x, query_y, query_z,
               norm_x, norm_y, norm_z, first_vertex, last_vertex,
        output ready
    );
endinterface

// ===== rtl/pip_res_if.sv =====
interface pip_res_if;
    logic        valid;
    logic        ready;
    logic        inside_res;
    logic [1:0]  plane_used;

    modport source (
        output valid, inside_res, plane_used,
        input  ready
    );
    modport sink (
        input  valid, inside_res, plane_used,
        output ready
    );
endinterface

// ===== rtl/pip_front.sv =====
module pip_front (
    input  logic                clk,
    input  logic                rst_n,
    input  pip_pkg::vert_t      item,
    input  logic                go,
    output pip_pkg::edge_pair_t pair
);

    localparam int CW = pip_pkg::COORD_WIDTH;
    localparam int DW = pip_pkg::DIFF_W;
    localparam int PW = pip_pkg::PROD_W;

    pip_pkg::axis_t  drop_axis_reg;
    pip_pkg::coord_t point_u_reg, point_v_reg;
    pip_pkg::coord_t start_u_reg, start_v_reg;
    pip_pkg::coord_t prev_u_reg, prev_v_reg;

    logic [CW:0]     mag_x, mag_y, mag_z;
    pip_pkg::axis_t  picked;
    pip_pkg::axis_t  axis_eff;
    pip_pkg::coord_t cur_u, cur_v, qry_u, qry_v, pnt_u, pnt_v, beg_u, beg_v;

    function automatic logic [CW:0] abs_val(input pip_pkg::coord_t a);
        logic signed [CW:0] e;
        e = (CW+1)'(a);
        return e[CW] ? (CW+1)'(-e) : e;
    endfunction

    function automatic pip_pkg::coord_t sel_u(input pip_pkg::axis_t ax,
                                              input pip_pkg::coord_t x,
                                              input pip_pkg::coord_t y,
                                              input pip_pkg::coord_t z);
        pip_pkg::coord_t r;
        unique case (ax)
            pip_pkg::AXIS_X: r = y;
            pip_pkg::AXIS_Y: r = z;
            pip_pkg::AXIS_Z: r = x;
            default:         r = y;
        endcase
        return r;
    endfunction

    function automatic pip_pkg::coord_t sel_v(input pip_pkg::axis_t ax,
                                              input pip_pkg::coord_t x,
                                              input pip_pkg::coord_t y,
                                              input pip_pkg::coord_t z);
        pip_pkg::coord_t r;
        unique case (ax)
            pip_pkg::AXIS_X: r = z;
            pip_pkg::AXIS_Y: r = x;
            pip_pkg::AXIS_Z: r = y;
            default:         r = z;
        endcase
        return r;
    endfunction

    // order the edge by v, then form both sides of the exact crossing compare
    function automatic pip_pkg::edge_prod_t edge_prep(input pip_pkg::coord_t au,
                                                      input pip_pkg::coord_t av,
                                                      input pip_pkg::coord_t bu,
                                                      input pip_pkg::coord_t bv,
                                                      input pip_pkg::coord_t pu,
                                                      input pip_pkg::coord_t pv);
        pip_pkg::coord_t    lu, lv, hu, hv;
        logic               swap;
        logic signed [DW-1:0] d_pu, d_v, d_u, d_pv;
        pip_pkg::edge_prod_t r;
        swap       = av > bv;
        lu         = swap ? bu : au;
        lv         = swap ? bv : av;
        hu         = swap ? au : bu;
        hv         = swap ? av : bv;
        d_pu       = DW'(pu) - DW'(lu);
        d_v        = DW'(hv) - DW'(lv);
        d_u        = DW'(hu) - DW'(lu);
        d_pv       = DW'(pv) - DW'(lv);
        r.in_range = (lv <= pv) && (pv < hv);
        r.lhs      = PW'(d_pu) * PW'(d_v);
        r.rhs      = PW'(d_u) * PW'(d_pv);
        return r;
    endfunction

    always_comb
    begin
        mag_x = abs_val(item.nx);
        mag_y = abs_val(item.ny);
        mag_z = abs_val(item.nz);
        if (mag_x > mag_y)
        begin
            picked = (mag_y > mag_z || mag_x > mag_z) ? pip_pkg::AXIS_X : pip_pkg::AXIS_Z;
        end
        else
        begin
            picked = (mag_x > mag_z || mag_y > mag_z) ? pip_pkg::AXIS_Y : pip_pkg::AXIS_Z;
        end
        axis_eff = item.first ? picked : drop_axis_reg;
        cur_u    = sel_u(axis_eff, item.vx, item.vy, item.vz);
        cur_v    = sel_v(axis_eff, item.vx, item.vy, item.vz);
        qry_u    = sel_u(axis_eff, item.qx, item.qy, item.qz);
        qry_v    = sel_v(axis_eff, item.qx, item.qy, item.qz);
        pnt_u    = item.first ? qry_u : point_u_reg;
        pnt_v    = item.first ? qry_v : point_v_reg;
        beg_u    = item.first ? cur_u : start_u_reg;
        beg_v    = item.first ? cur_v : start_v_reg;

        pair.e_open  = edge_prep(prev_u_reg, prev_v_reg, cur_u, cur_v, pnt_u, pnt_v);
        pair.e_close = edge_prep(cur_u, cur_v, beg_u, beg_v, pnt_u, pnt_v);
        pair.first   = item.first;
        pair.last    = item.last;
        pair.axis    = axis_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_axis_reg <= pip_pkg::AXIS_X;
            point_u_reg   <= '0;
            point_v_reg   <= '0;
            start_u_reg   <= '0;
            start_v_reg   <= '0;
            prev_u_reg    <= '0;
            prev_v_reg    <= '0;
        end
        else if (go)
        begin
            drop_axis_reg <= axis_eff;
            point_u_reg   <= pnt_u;
            point_v_reg   <= pnt_v;
            start_u_reg   <= beg_u;
            start_v_reg   <= beg_v;
            prev_u_reg    <= cur_u;
            prev_v_reg    <= cur_v;
        end
    end

endmodule

// ===== rtl/pip_parity.sv =====
module pip_parity (
    input  logic                clk,
    input  logic                rst_n,
    input  pip_pkg::edge_pair_t pair,
    input  logic                go,
    output logic                in_poly
);

    logic parity_reg;
    logic t_open, t_close, base;

    always_comb
    begin
        t_open  = !pair.first && pair.e_open.in_range
                  && (pair.e_open.lhs < pair.e_open.rhs);
        t_close = pair.last && pair.e_close.in_range
                  && (pair.e_close.lhs < pair.e_close.rhs);
        base    = pair.first ? 1'b0 : (parity_reg ^ t_open);
        in_poly = base ^ t_close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 1'b0;
        end
        else if (go)
        begin
            parity_reg <= in_poly;
        end
    end

endmodule

// ===== rtl/point_in_polygon_crossing_test.sv =====
// Point-in-polygon crossing-parity test. Vertices stream in one request per
// cycle, with no gaps needed, while input is not held off; the vertex marked
// first_vertex also latches the query point and normal, and the one marked
// last_vertex closes the polygon and yields one result (inside flag and dropped
// axis) in the result register. Each vertex passes an input register, a stage
// of four 17x17 products for the current and closing edges, and a compare/parity
// stage into the result register. Input is held off only while a result sits
// unread in the result register and the pipeline behind it is full.
module point_in_polygon_crossing_test (
    input  logic       clk,
    input  logic       rst_n,
    pip_vert_if.sink   vert,
    pip_res_if.source  res
);

    pip_pkg::vert_t      s1_reg;
    logic                s1_valid_reg;
    pip_pkg::edge_pair_t s2_reg;
    logic                s2_valid_reg;
    pip_pkg::edge_pair_t pair_next;
    logic                inside_next;
    logic                out_valid_reg;
    logic                inside_reg;
    pip_pkg::axis_t      plane_reg;

    logic out_free, s2_go, s2_can, s1_go, s1_can, out_ld, in_take;

    always_comb
    begin
        out_free = !out_valid_reg || res.ready;
        s2_go    = s2_valid_reg && (!s2_reg.last || out_free);
        s2_can   = !s2_valid_reg || s2_go;
        s1_go    = s1_valid_reg && s2_can;
        s1_can   = !s1_valid_reg || s1_go;
        out_ld   = s2_go && s2_reg.last;
        in_take  = vert.valid && s1_can;
    end

    assign vert.ready     = s1_can;
    assign res.valid      = out_valid_reg;
    assign res.inside_res = inside_reg;
    assign res.plane_used = plane_reg;

    pip_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (s1_reg),
        .go    (s1_go),
        .pair  (pair_next)
    );

    pip_parity u_parity (
        .clk     (clk),
        .rst_n   (rst_n),
        .pair    (s2_reg),
        .go      (s2_go),
        .in_poly (inside_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_can)
            begin
                s1_valid_reg <= vert.valid;
            end
            if (s2_can)
            begin
                s2_valid_reg <= s1_go;
            end
            if (out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_reg.vx    <= vert.vert_x;
            s1_reg.vy    <= vert.vert_y;
            s1_reg.vz    <= vert.vert_z;
            s1_reg.qx    <= vert.query_x;
            s1_reg.qy    <= vert.query_y;
            s1_reg.qz    <= vert.query_z;
            s1_reg.nx    <= vert.norm_x;
            s1_reg.ny    <= vert.norm_y;
            s1_reg.nz    <= vert.norm_z;
            s1_reg.first <= vert.first_vertex;
            s1_reg.last  <= vert.last_vertex;
        end
        if (s1_go)
        begin
            s2_reg <= pair_next;
        end
        if (out_ld)
        begin
            inside_reg <= inside_next;
            plane_reg  <= s2_reg.axis;
        end
    end

endmodule

// ===== rtl/pip_checker.sv =====
module pip_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       inside_res,
    input logic [1:0] plane_used
);

    // unread result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(inside_res) && $stable(plane_used))
        else $error("result payload changed while stalled");

    // the only back-pressure source is an unread result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input held off without a blocked result");

    a_plane_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> plane_used == pip_pkg::AXIS_X || plane_used == pip_pkg::AXIS_Y
                      || plane_used == pip_pkg::AXIS_Z)
        else $error("illegal plane code");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid}))
        else $error("handshake signal unknown");

endmodule

bind point_in_polygon_crossing_test pip_checker u_pip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vert.valid),
    .in_ready   (vert.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .inside_res (res.inside_res),
    .plane_used (res.plane_used)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic           in_poly;
        pip_pkg::axis_t plane;
    } verdict_t;

    typedef struct {
        pip_pkg::vert_t v;
        bit             typed;
        verdict_t       want;
    } req_row_t;

    typedef enum int {SP_TIGHT, SP_MID, SP_FULL, SP_EDGE} spread_t;
    typedef enum int {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    pip_vert_if vert_ch ();
    pip_res_if  res_ch ();

    point_in_polygon_crossing_test dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vert  (vert_ch),
        .res   (res_ch)
    );

    verdict_t pending_verdicts[$];
    int       errors;
    int       vertices_sent;
    int       polygons_sent;
    int       verdicts_checked;
    int       inside_count;
    int       burst_left;
    int       rx_left;
    rx_mode_t rx_mode;

    // projected polygon state
    pip_pkg::axis_t drop_q   = pip_pkg::AXIS_X;
    longint         pt_u     = 0;
    longint         pt_v     = 0;
    longint         st_u     = 0;
    longint         st_v     = 0;
    longint         pv_u     = 0;
    longint         pv_v     = 0;
    bit             parity_q = 1'b0;

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic pip_pkg::axis_t pick_plane(input pip_pkg::coord_t nx, ny, nz);
        int ax, ay, az;
        ax = (nx < 0) ? -int'(nx) : int'(nx);
        ay = (ny < 0) ? -int'(ny) : int'(ny);
        az = (nz < 0) ? -int'(nz) : int'(nz);
        if (ax > ay)
            return (ay > az || ax > az) ? pip_pkg::AXIS_X : pip_pkg::AXIS_Z;
        return (ax > az || ay > az) ? pip_pkg::AXIS_Y : pip_pkg::AXIS_Z;
    endfunction

    function automatic void project(input pip_pkg::axis_t ax,
                                    input pip_pkg::coord_t x, y, z,
                                    output longint u, v);
        unique case (ax)
            pip_pkg::AXIS_X:
            begin
                u = y;
                v = z;
            end
            pip_pkg::AXIS_Y:
            begin
                u = z;
                v = x;
            end
            default:
            begin
                u = x;
                v = y;
            end
        endcase
    endfunction

    // +u ray from the query point against edge a-b, exact in integers
    function automatic bit crosses(input longint au, av, bu, bv);
        longint t;
        if (av > bv)
        begin
            t = au; au = bu; bu = t;
            t = av; av = bv; bv = t;
        end
        if (av > pt_v || pt_v >= bv)
            return 1'b0;
        return (pt_u - au) * (bv - av) < (bu - au) * (pt_v - av);
    endfunction

    function automatic void crossing_step(input pip_pkg::vert_t v, output bit emits,
                                          output verdict_t r);
        longint cu, cv;
        if (v.first)
        begin
            drop_q = pick_plane(v.nx, v.ny, v.nz);
            project(drop_q, v.qx, v.qy, v.qz, pt_u, pt_v);
            project(drop_q, v.vx, v.vy, v.vz, cu, cv);
            st_u     = cu;
            st_v     = cv;
            parity_q = 1'b0;
        end
        else
        begin
            project(drop_q, v.vx, v.vy, v.vz, cu, cv);
            if (crosses(pv_u, pv_v, cu, cv))
                parity_q ^= 1'b1;
        end
        pv_u  = cu;
        pv_v  = cv;
        emits = v.last;
        if (v.last && crosses(cu, cv, st_u, st_v))
            parity_q ^= 1'b1;
        r.in_poly = parity_q;
        r.plane   = drop_q;
    endfunction

    // typed rows are single vertices, so never inside
    function automatic req_row_t mk(input int vx, vy, vz, qx, qy, qz, nx, ny, nz,
                                    input bit f, l, input bit typed = 1'b0,
                                    input pip_pkg::axis_t pl = pip_pkg::AXIS_X);
        req_row_t r;
        r.v = {pip_pkg::coord_t'(vx), pip_pkg::coord_t'(vy), pip_pkg::coord_t'(vz),
               pip_pkg::coord_t'(qx), pip_pkg::coord_t'(qy), pip_pkg::coord_t'(qz),
               pip_pkg::coord_t'(nx), pip_pkg::coord_t'(ny), pip_pkg::coord_t'(nz),
               f, l};
        r.typed        = typed;
        r.want.in_poly = 1'b0;
        r.want.plane   = pl;
        return r;
    endfunction

    function automatic pip_pkg::coord_t rand_coord(input spread_t sp);
        case (sp)
            SP_TIGHT: return pip_pkg::coord_t'(int'($urandom_range(0, 24)) - 12);
            SP_MID:   return pip_pkg::coord_t'(int'($urandom_range(0, 2000)) - 1000);
            SP_FULL:  return pip_pkg::coord_t'($urandom);
            default:
                case ($urandom_range(0, 5))
                    0:       return 16'sh8000;
                    1:       return 16'sh8001;
                    2:       return 16'shFFFF;
                    3:       return 16'sh0000;
                    4:       return 16'sh7FFE;
                    default: return 16'sh7FFF;
                endcase
        endcase
    endfunction

    function automatic int next_gap();
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        return gap;
    endfunction

    task automatic push_vertex(input req_row_t r, input int gap);
        bit       emits;
        verdict_t calc;
        if (gap > 0)
        begin
            vert_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vert_ch.valid        <= 1'b1;
        vert_ch.vert_x       <= r.v.vx;
        vert_ch.vert_y       <= r.v.vy;
        vert_ch.vert_z       <= r.v.vz;
        vert_ch.query_x      <= r.v.qx;
        vert_ch.query_y      <= r.v.qy;
        vert_ch.query_z      <= r.v.qz;
        vert_ch.norm_x       <= r.v.nx;
        vert_ch.norm_y       <= r.v.ny;
        vert_ch.norm_z       <= r.v.nz;
        vert_ch.first_vertex <= r.v.first;
        vert_ch.last_vertex  <= r.v.last;
        @(posedge clk);
        while (!vert_ch.ready)
            @(posedge clk);
        crossing_step(r.v, emits, calc);
        if (emits)
            pending_verdicts.push_back(r.typed ? r.want : calc);
        vertices_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        vert_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   res_ch.ready <= 1'b1;
            RX_CHOPPY: res_ch.ready <= ($urandom_range(0, 3) != 0);
            default:   res_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unrequested verdict inside_res=%0b plane_used=%0d",
                         $time, res_ch.inside_res, res_ch.plane_used);
                errors++;
            end
            else
            begin
                if (res_ch.inside_res !== pending_verdicts[0].in_poly)
                begin
                    $display("%0t: inside_res expected %0b got %0b", $time,
                             pending_verdicts[0].in_poly, res_ch.inside_res);
                    errors++;
                end
                if (res_ch.plane_used !== pending_verdicts[0].plane)
                begin
                    $display("%0t: plane_used expected %0d got %0d", $time,
                             pending_verdicts[0].plane, res_ch.plane_used);
                    errors++;
                end
                inside_count += pending_verdicts[0].in_poly;
                verdicts_checked++;
                void'(pending_verdicts.pop_front());
            end
        end
    end

    initial
    begin
        req_row_t    directed[$];
        req_row_t    r;
        spread_t     sp;
        spread_t     nsp;
        int          n;
        int          broken;
        logic [159:0] noise;

        rst_n                = 1'b0;
        vert_ch.valid        = 1'b0;
        vert_ch.vert_x       = '0;
        vert_ch.vert_y       = '0;
        vert_ch.vert_z       = '0;
        vert_ch.query_x      = '0;
        vert_ch.query_y      = '0;
        vert_ch.query_z      = '0;
        vert_ch.norm_x       = '0;
        vert_ch.norm_y       = '0;
        vert_ch.norm_z       = '0;
        vert_ch.first_vertex = 1'b0;
        vert_ch.last_vertex  = 1'b0;

        // vertices before any first vertex use the reset state
        directed.push_back(mk(0, 5, -5, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(0, 5, 5, 0, 0, 0, 0, 0, 0, 0, 1));
        // single-vertex polygons: plane choice, ties, zero normal
        directed.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                              0, 0, 0, 1, 1, 1, pip_pkg::AXIS_Z));
        directed.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                              5, 0, 0, 1, 1, 1, pip_pkg::AXIS_X));
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, -7, 0, 1, 1, 1, pip_pkg::AXIS_Y));
        directed.push_back(mk(1, 2, 3, 4, 5, 6, -32768, 32767, 0, 1, 1, 1,
                              pip_pkg::AXIS_X));
        directed.push_back(mk(1, 2, 3, 4, 5, 6, 3, 3, 0, 1, 1, 1, pip_pkg::AXIS_Y));
        directed.push_back(mk(1, 2, 3, 4, 5, 6, 3, 0, 3, 1, 1, 1, pip_pkg::AXIS_Z));
        directed.push_back(mk(1, 2, 3, 4, 5, 6, 0, 3, -3, 1, 1, 1, pip_pkg::AXIS_Z));
        directed.push_back(mk(1, 2, 3, 4, 5, 6, -32768, -32768, -32768,
                              1, 1, 1, pip_pkg::AXIS_Z));
        directed.push_back(mk(1, 2, 3, 4, 5, 6, 0, -32768, 32767, 1, 1, 1,
                              pip_pkg::AXIS_Y));
        // square around the origin in the XY plane
        directed.push_back(mk(-10, -10, 0, 0, 0, 0, 0, 0, 9, 1, 0));
        directed.push_back(mk(10, -10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(10, 10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(-10, 10, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // full-range triangles, widest products
        directed.push_back(mk(0, -32768, -32768, 0, 32766, 0, 1, 0, 0, 1, 0));
        directed.push_back(mk(0, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(0, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, 32767,
                              -1, 0, 0, 1, 0));
        directed.push_back(mk(0, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(0, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 1));
        // horizontal edge through the query point, query on that edge
        directed.push_back(mk(0, 0, -5, 0, 0, 0, 0, 4, 1, 1, 0));
        directed.push_back(mk(0, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            push_vertex(directed[i], next_gap());
        drain();

        r.typed = 1'b0;
        r.want  = '0;
        while (vertices_sent < 1300)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
                r.v   = noise[$bits(pip_pkg::vert_t)-1:0];
                push_vertex(r, next_gap());
            end
            else
            begin
                n      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12)
                                                    : $urandom_range(3, 6);
                sp     = spread_t'($urandom_range(0, 3));
                nsp    = spread_t'($urandom_range(0, 3));
                broken = $urandom_range(0, 19);
                for (int i = 0; i < n; i++)
                begin
                    noise   = {$urandom, $urandom, $urandom, $urandom, $urandom};
                    r.v     = noise[$bits(pip_pkg::vert_t)-1:0];
                    r.v.vx  = rand_coord(sp);
                    r.v.vy  = rand_coord(sp);
                    r.v.vz  = rand_coord(sp);
                    r.v.first = (i == 0) && (broken != 1);
                    r.v.last  = (i == n - 1) && (broken != 2);
                    if (i == 0)
                    begin
                        r.v.qx = rand_coord(sp);
                        r.v.qy = rand_coord(sp);
                        r.v.qz = rand_coord(sp);
                        r.v.nx = rand_coord(nsp);
                        r.v.ny = rand_coord(nsp);
                        r.v.nz = rand_coord(nsp);
                        if ($urandom_range(0, 9) == 0)
                        begin
                            r.v.nx = '0;
                            r.v.ny = '0;
                            r.v.nz = '0;
                        end
                    end
                    push_vertex(r, next_gap());
                end
                polygons_sent++;
                if (polygons_sent % 64 == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);

        $display("run: %0d vertices, %0d random polygons, %0d verdicts checked (%0d inside)",
                 vertices_sent, polygons_sent, verdicts_checked, inside_count);
        $display("run: all three projection planes, full-range and tight coordinates");
        if (errors == 0 && pending_verdicts.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
